>>> design/mbvs_pkg.sv
// shared types and constants for the branch variable selector
package mbvs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAR_W     = 10;
    localparam int NUM_VARS  = 1024;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 16;
    localparam int TOTAL_W   = 58;
    localparam int OBS_W     = 11;
    localparam int SCORE_W   = 64;
    localparam int OP_W      = 64;
    localparam int DIV_W     = 16;
    localparam int ROW_W     = 2 * (SUM_W + CNT_W);
    localparam int DIST_W    = FRAC_BITS + 1;
    localparam int STEP_W    = 7;

    localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0]  ONE_FX  = SUM_W'(1) << FRAC_BITS;
    localparam logic [DIST_W-1:0] ONE_D   = DIST_W'(1) << FRAC_BITS;

    localparam logic [0:0] REG_STRATEGY  = 1'b0;
    localparam logic [0:0] REG_TOLERANCE = 1'b1;

    // one queued item, already classified by the front
    typedef struct packed {
        logic                  is_record;
        logic                  cand;
        logic                  strategy;
        logic                  last;
        logic [VAR_W-1:0]      var_index;
        logic                  direction;
        logic [SUM_W-1:0]      delta_q;
        logic [FRAC_BITS-1:0]  fraction;
        logic [FRAC_BITS-1:0]  frac;
        logic [DIST_W-1:0]     near_dist;
    } entry_t;

    // one pseudo-cost table row
    typedef struct packed {
        logic [SUM_W-1:0] dsum;
        logic [CNT_W-1:0] dcnt;
        logic [SUM_W-1:0] usum;
        logic [CNT_W-1:0] ucnt;
    } row_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_READ,
        ST_RATIO, ST_RATIO_W, ST_OLD, ST_OLD_W, ST_NEW, ST_NEW_W, ST_WRITE,
        ST_DCOST, ST_DCOST_W, ST_UCOST, ST_UCOST_W,
        ST_DSCALE, ST_DSCALE_W, ST_USCALE, ST_USCALE_W, ST_PROD, ST_PROD_W,
        ST_SELECT, ST_EMIT
    } state_t;

endpackage

>>> design/mbvs_ram.sv
// generic single write port ram with registered read
module mbvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/mbvs_div.sv
// iterative restoring divider, one quotient bit per cycle
module mbvs_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mbvs_pkg::OP_W-1:0]    dividend,
    input  logic [mbvs_pkg::DIV_W-1:0]   divisor,
    output logic                         done,
    output logic [mbvs_pkg::OP_W-1:0]    quotient
);

    logic [mbvs_pkg::OP_W-1:0]   q_reg;
    logic [mbvs_pkg::DIV_W-1:0]  rem_reg;
    logic [mbvs_pkg::DIV_W-1:0]  dvs_reg;
    logic [mbvs_pkg::STEP_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [mbvs_pkg::DIV_W:0]    trial;
    logic                        fits;

    // one shift and trial subtract
    assign trial = {rem_reg, q_reg[mbvs_pkg::OP_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= mbvs_pkg::STEP_W'(mbvs_pkg::OP_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == mbvs_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= mbvs_pkg::DIV_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[mbvs_pkg::DIV_W-1:0];
            end
            q_reg <= {q_reg[mbvs_pkg::OP_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> design/mbvs_mul.sv
// iterative shift and add multiplier, one multiplier bit per cycle
module mbvs_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mbvs_pkg::OP_W-1:0]     a,
    input  logic [mbvs_pkg::OP_W-1:0]     b,
    output logic                          done,
    output logic [2*mbvs_pkg::OP_W-1:0]   product
);

    logic [mbvs_pkg::OP_W-1:0]   a_reg;
    logic [mbvs_pkg::OP_W-1:0]   hi_reg;
    logic [mbvs_pkg::OP_W-1:0]   lo_reg;
    logic [mbvs_pkg::STEP_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [mbvs_pkg::OP_W:0]     sum;

    // partial product add
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= mbvs_pkg::STEP_W'(mbvs_pkg::OP_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == mbvs_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[mbvs_pkg::OP_W:1];
            lo_reg <= {sum[0], lo_reg[mbvs_pkg::OP_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

>>> design/mbvs_front.sv
// front end: accepts items, classifies them and queues the ones with work
module mbvs_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [mbvs_pkg::VAR_W-1:0]      var_index,
    input  logic                            direction,
    input  logic signed [31:0]              obj_change,
    input  logic [mbvs_pkg::FRAC_BITS-1:0]  branch_fraction,
    input  logic signed [31:0]              primal_value,
    input  logic                            is_integer,
    input  logic                            last_offer,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            clearing,
    input  logic                            pop,
    output mbvs_pkg::entry_t                head,
    output logic                            head_valid
);

    localparam int DEPTH = 2;

    logic                           strategy_reg;
    logic [mbvs_pkg::FRAC_BITS-1:0] tol_reg;
    mbvs_pkg::entry_t               entries_reg [DEPTH];
    logic                           wr_ptr_reg;
    logic                           rd_ptr_reg;
    logic [1:0]                     count_reg;
    logic [mbvs_pkg::FRAC_BITS-1:0] frac;
    logic [mbvs_pkg::DIST_W-1:0]    comp;
    logic [mbvs_pkg::DIST_W-1:0]    near_dist;
    logic                           cand;
    logic                           keep;
    logic                           push;
    mbvs_pkg::entry_t               entry;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= 1'b1;
            tol_reg      <= mbvs_pkg::FRAC_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbvs_pkg::REG_STRATEGY:  strategy_reg <= cfg_data[0];
                mbvs_pkg::REG_TOLERANCE: tol_reg      <= cfg_data;
                default:                 tol_reg      <= tol_reg;
            endcase
        end
    end

    // distance to the nearest integer and candidate test
    assign frac      = primal_value[mbvs_pkg::FRAC_BITS-1:0];
    assign comp      = mbvs_pkg::ONE_D - {1'b0, frac};
    assign near_dist = ({1'b0, frac} < comp) ? {1'b0, frac} : comp;
    assign cand      = is_integer && (near_dist > {1'b0, tol_reg});

    // drop items with no effect
    assign keep = !mode ? (!obj_change[31] && (branch_fraction != '0))
                        : (cand || last_offer);

    always_comb
    begin
        entry.is_record = !mode;
        entry.cand      = cand;
        entry.strategy  = strategy_reg;
        entry.last      = last_offer;
        entry.var_index = var_index;
        entry.direction = direction;
        entry.delta_q   = {1'b0, obj_change[30:0], {mbvs_pkg::FRAC_BITS{1'b0}}};
        entry.fraction  = branch_fraction;
        entry.frac      = frac;
        entry.near_dist = near_dist;
    end

    assign in_stall = clearing || (count_reg == 2'(DEPTH));
    assign push     = in_valid && !in_stall && keep;

    // two entry queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= entry;
        end
    end

    assign head       = entries_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;

endmodule

>>> design/mbvs_back.sv
// back end: table clearing, pseudo-cost updates, scoring and selection
module mbvs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbvs_pkg::entry_t            head,
    input  logic                        head_valid,
    output logic                        pop,
    output logic                        clearing,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [mbvs_pkg::VAR_W-1:0]  chosen_index
);

    mbvs_pkg::state_t state_reg;
    mbvs_pkg::state_t state_next;

    mbvs_pkg::entry_t               cur_reg;
    mbvs_pkg::row_t                 row_reg;
    mbvs_pkg::row_t                 rdata;
    mbvs_pkg::row_t                 wrow;
    logic [mbvs_pkg::VAR_W-1:0]     clr_addr_reg;
    logic [mbvs_pkg::SUM_W-1:0]     ratio_reg;
    logic [mbvs_pkg::SUM_W-1:0]     old_reg;
    logic [mbvs_pkg::SUM_W-1:0]     new_reg;
    logic [mbvs_pkg::SUM_W-1:0]     sum_new_reg;
    logic [mbvs_pkg::CNT_W-1:0]     cnt_new_reg;
    logic [mbvs_pkg::SUM_W-1:0]     dcost_reg;
    logic [mbvs_pkg::SUM_W-1:0]     ucost_reg;
    logic [mbvs_pkg::SUM_W:0]       dn_reg;
    logic [mbvs_pkg::SUM_W:0]       up_reg;
    logic [mbvs_pkg::SCORE_W-1:0]   score_reg;
    logic [mbvs_pkg::TOTAL_W-1:0]   dtotal_reg;
    logic [mbvs_pkg::TOTAL_W-1:0]   utotal_reg;
    logic [mbvs_pkg::OBS_W-1:0]     dobs_reg;
    logic [mbvs_pkg::OBS_W-1:0]     uobs_reg;
    logic [mbvs_pkg::SCORE_W-1:0]   best_score_reg;
    logic [mbvs_pkg::VAR_W-1:0]     best_index_reg;
    logic                           any_reg;
    logic                           out_valid_reg;
    logic                           found_reg;
    logic [mbvs_pkg::VAR_W-1:0]     chosen_index_reg;

    logic                           ram_we;
    logic [mbvs_pkg::VAR_W-1:0]     ram_waddr;
    logic                           ram_re;
    logic                           div_start;
    logic [mbvs_pkg::OP_W-1:0]      div_a;
    logic [mbvs_pkg::DIV_W-1:0]     div_b;
    logic                           div_done;
    logic [mbvs_pkg::OP_W-1:0]      div_q;
    logic                           mul_start;
    logic [mbvs_pkg::OP_W-1:0]      mul_a;
    logic [mbvs_pkg::OP_W-1:0]      mul_b;
    logic                           mul_done;
    logic [2*mbvs_pkg::OP_W-1:0]    mul_p;
    logic                           emit;

    logic [mbvs_pkg::SUM_W-1:0]     sel_sum;
    logic [mbvs_pkg::CNT_W-1:0]     sel_cnt;
    logic [mbvs_pkg::SUM_W:0]       sum_add;
    logic [mbvs_pkg::SUM_W-1:0]     sum_sat;
    logic [mbvs_pkg::CNT_W-1:0]     cnt_sat;
    logic [mbvs_pkg::DIST_W-1:0]    comp;
    logic                           out_free;

    // shared arithmetic units
    mbvs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    mbvs_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // pseudo-cost table
    mbvs_ram #(
        .WIDTH (mbvs_pkg::ROW_W),
        .DEPTH (mbvs_pkg::NUM_VARS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wrow),
        .re    (ram_re),
        .raddr (head.var_index),
        .rdata (rdata)
    );

    // record arithmetic for the chosen direction
    assign sel_sum = cur_reg.direction ? row_reg.usum : row_reg.dsum;
    assign sel_cnt = cur_reg.direction ? row_reg.ucnt : row_reg.dcnt;
    assign sum_add = {1'b0, sel_sum} + {1'b0, ratio_reg};
    assign sum_sat = sum_add[mbvs_pkg::SUM_W] ? mbvs_pkg::SUM_MAX
                                              : sum_add[mbvs_pkg::SUM_W-1:0];
    assign cnt_sat = (sel_cnt == mbvs_pkg::CNT_MAX) ? sel_cnt : sel_cnt + 1'b1;
    assign comp    = mbvs_pkg::ONE_D - {1'b0, cur_reg.frac};
    assign out_free = !out_valid_reg || !out_stall;

    // row written back, or zeros while clearing
    always_comb
    begin
        wrow = row_reg;
        if (state_reg == mbvs_pkg::ST_CLEAR)
        begin
            wrow = '0;
        end
        else if (cur_reg.direction)
        begin
            wrow.usum = sum_new_reg;
            wrow.ucnt = cnt_new_reg;
        end
        else
        begin
            wrow.dsum = sum_new_reg;
            wrow.dcnt = cnt_new_reg;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbvs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and unit controls
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg.var_index;
        ram_re     = 1'b0;
        div_start  = 1'b0;
        div_a      = '0;
        div_b      = '0;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        emit       = 1'b0;
        unique case (state_reg)
            mbvs_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == mbvs_pkg::VAR_W'(mbvs_pkg::NUM_VARS - 1))
                begin
                    state_next = mbvs_pkg::ST_IDLE;
                end
            end
            mbvs_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop    = 1'b1;
                    ram_re = 1'b1;
                    if (head.is_record || (head.cand && head.strategy))
                    begin
                        state_next = mbvs_pkg::ST_READ;
                    end
                    else if (head.cand)
                    begin
                        state_next = mbvs_pkg::ST_SELECT;
                    end
                    else
                    begin
                        state_next = mbvs_pkg::ST_EMIT;
                    end
                end
            end
            mbvs_pkg::ST_READ:
            begin
                state_next = cur_reg.is_record ? mbvs_pkg::ST_RATIO : mbvs_pkg::ST_DCOST;
            end
            mbvs_pkg::ST_RATIO:
            begin
                div_start  = 1'b1;
                div_a      = mbvs_pkg::OP_W'(cur_reg.delta_q);
                div_b      = cur_reg.fraction;
                state_next = mbvs_pkg::ST_RATIO_W;
            end
            mbvs_pkg::ST_RATIO_W:
            begin
                if (div_done)
                begin
                    state_next = mbvs_pkg::ST_OLD;
                end
            end
            mbvs_pkg::ST_OLD:
            begin
                if (sel_cnt != '0)
                begin
                    div_start  = 1'b1;
                    div_a      = mbvs_pkg::OP_W'(sel_sum);
                    div_b      = sel_cnt;
                    state_next = mbvs_pkg::ST_OLD_W;
                end
                else
                begin
                    state_next = mbvs_pkg::ST_NEW;
                end
            end
            mbvs_pkg::ST_OLD_W:
            begin
                if (div_done)
                begin
                    state_next = mbvs_pkg::ST_NEW;
                end
            end
            mbvs_pkg::ST_NEW:
            begin
                div_start  = 1'b1;
                div_a      = mbvs_pkg::OP_W'(sum_new_reg);
                div_b      = cnt_new_reg;
                state_next = mbvs_pkg::ST_NEW_W;
            end
            mbvs_pkg::ST_NEW_W:
            begin
                if (div_done)
                begin
                    state_next = mbvs_pkg::ST_WRITE;
                end
            end
            mbvs_pkg::ST_WRITE:
            begin
                ram_we     = 1'b1;
                state_next = mbvs_pkg::ST_IDLE;
            end
            mbvs_pkg::ST_DCOST:
            begin
                if (row_reg.dcnt != '0)
                begin
                    div_start  = 1'b1;
                    div_a      = mbvs_pkg::OP_W'(row_reg.dsum);
                    div_b      = row_reg.dcnt;
                    state_next = mbvs_pkg::ST_DCOST_W;
                end
                else if (dobs_reg != '0)
                begin
                    div_start  = 1'b1;
                    div_a      = mbvs_pkg::OP_W'(dtotal_reg);
                    div_b      = mbvs_pkg::DIV_W'(dobs_reg);
                    state_next = mbvs_pkg::ST_DCOST_W;
                end
                else
                begin
                    state_next = mbvs_pkg::ST_UCOST;
                end
            end
            mbvs_pkg::ST_DCOST_W:
            begin
                if (div_done)
                begin
                    state_next = mbvs_pkg::ST_UCOST;
                end
            end
            mbvs_pkg::ST_UCOST:
            begin
                if (row_reg.ucnt != '0)
                begin
                    div_start  = 1'b1;
                    div_a      = mbvs_pkg::OP_W'(row_reg.usum);
                    div_b      = row_reg.ucnt;
                    state_next = mbvs_pkg::ST_UCOST_W;
                end
                else if (uobs_reg != '0)
                begin
                    div_start  = 1'b1;
                    div_a      = mbvs_pkg::OP_W'(utotal_reg);
                    div_b      = mbvs_pkg::DIV_W'(uobs_reg);
                    state_next = mbvs_pkg::ST_UCOST_W;
                end
                else
                begin
                    state_next = mbvs_pkg::ST_DSCALE;
                end
            end
            mbvs_pkg::ST_UCOST_W:
            begin
                if (div_done)
                begin
                    state_next = mbvs_pkg::ST_DSCALE;
                end
            end
            mbvs_pkg::ST_DSCALE:
            begin
                mul_start  = 1'b1;
                mul_a      = mbvs_pkg::OP_W'(dcost_reg);
                mul_b      = mbvs_pkg::OP_W'(cur_reg.frac);
                state_next = mbvs_pkg::ST_DSCALE_W;
            end
            mbvs_pkg::ST_DSCALE_W:
            begin
                if (mul_done)
                begin
                    state_next = mbvs_pkg::ST_USCALE;
                end
            end
            mbvs_pkg::ST_USCALE:
            begin
                mul_start  = 1'b1;
                mul_a      = mbvs_pkg::OP_W'(ucost_reg);
                mul_b      = mbvs_pkg::OP_W'(comp);
                state_next = mbvs_pkg::ST_USCALE_W;
            end
            mbvs_pkg::ST_USCALE_W:
            begin
                if (mul_done)
                begin
                    state_next = mbvs_pkg::ST_PROD;
                end
            end
            mbvs_pkg::ST_PROD:
            begin
                mul_start  = 1'b1;
                mul_a      = mbvs_pkg::OP_W'(dn_reg) + 1'b1;
                mul_b      = mbvs_pkg::OP_W'(up_reg) + 1'b1;
                state_next = mbvs_pkg::ST_PROD_W;
            end
            mbvs_pkg::ST_PROD_W:
            begin
                if (mul_done)
                begin
                    state_next = mbvs_pkg::ST_SELECT;
                end
            end
            mbvs_pkg::ST_SELECT:
            begin
                state_next = cur_reg.last ? mbvs_pkg::ST_EMIT : mbvs_pkg::ST_IDLE;
            end
            mbvs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = mbvs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbvs_pkg::ST_IDLE;
            end
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg   <= head;
            score_reg <= mbvs_pkg::SCORE_W'(head.near_dist);
        end
        if (state_reg == mbvs_pkg::ST_READ)
        begin
            row_reg <= rdata;
        end
        if (state_reg == mbvs_pkg::ST_RATIO_W && div_done)
        begin
            ratio_reg <= (div_q[mbvs_pkg::OP_W-1:mbvs_pkg::SUM_W] != '0)
                         ? mbvs_pkg::SUM_MAX : div_q[mbvs_pkg::SUM_W-1:0];
        end
        if (state_reg == mbvs_pkg::ST_OLD)
        begin
            sum_new_reg <= sum_sat;
            cnt_new_reg <= cnt_sat;
            old_reg     <= '0;
        end
        if (state_reg == mbvs_pkg::ST_OLD_W && div_done)
        begin
            old_reg <= div_q[mbvs_pkg::SUM_W-1:0];
        end
        if (state_reg == mbvs_pkg::ST_NEW_W && div_done)
        begin
            new_reg <= div_q[mbvs_pkg::SUM_W-1:0];
        end
        if (state_reg == mbvs_pkg::ST_DCOST)
        begin
            dcost_reg <= mbvs_pkg::ONE_FX;
        end
        if (state_reg == mbvs_pkg::ST_DCOST_W && div_done)
        begin
            dcost_reg <= div_q[mbvs_pkg::SUM_W-1:0];
        end
        if (state_reg == mbvs_pkg::ST_UCOST)
        begin
            ucost_reg <= mbvs_pkg::ONE_FX;
        end
        if (state_reg == mbvs_pkg::ST_UCOST_W && div_done)
        begin
            ucost_reg <= div_q[mbvs_pkg::SUM_W-1:0];
        end
        if (state_reg == mbvs_pkg::ST_DSCALE_W && mul_done)
        begin
            dn_reg <= mul_p[mbvs_pkg::FRAC_BITS +: mbvs_pkg::SUM_W+1];
        end
        if (state_reg == mbvs_pkg::ST_USCALE_W && mul_done)
        begin
            up_reg <= mul_p[mbvs_pkg::FRAC_BITS +: mbvs_pkg::SUM_W+1];
        end
        // product score saturates when bits above the 64 bit window are set
        if (state_reg == mbvs_pkg::ST_PROD_W && mul_done)
        begin
            score_reg <= (mul_p[2*mbvs_pkg::OP_W-1:mbvs_pkg::SCORE_W+mbvs_pkg::FRAC_BITS] != '0)
                         ? {mbvs_pkg::SCORE_W{1'b1}}
                         : mul_p[mbvs_pkg::FRAC_BITS +: mbvs_pkg::SCORE_W];
        end
    end

    // clearing address, mean totals, selection and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            dtotal_reg       <= '0;
            utotal_reg       <= '0;
            dobs_reg         <= '0;
            uobs_reg         <= '0;
            best_score_reg   <= '0;
            best_index_reg   <= '0;
            any_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            chosen_index_reg <= '0;
        end
        else
        begin
            if (state_reg == mbvs_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == mbvs_pkg::ST_WRITE)
            begin
                if (cur_reg.direction)
                begin
                    utotal_reg <= utotal_reg - mbvs_pkg::TOTAL_W'(old_reg)
                                             + mbvs_pkg::TOTAL_W'(new_reg);
                    if (sel_cnt == '0)
                    begin
                        uobs_reg <= uobs_reg + 1'b1;
                    end
                end
                else
                begin
                    dtotal_reg <= dtotal_reg - mbvs_pkg::TOTAL_W'(old_reg)
                                             + mbvs_pkg::TOTAL_W'(new_reg);
                    if (sel_cnt == '0)
                    begin
                        dobs_reg <= dobs_reg + 1'b1;
                    end
                end
            end
            // first best candidate wins ties
            if (state_reg == mbvs_pkg::ST_SELECT)
            begin
                if (!any_reg || (score_reg > best_score_reg))
                begin
                    best_score_reg <= score_reg;
                    best_index_reg <= cur_reg.var_index;
                    any_reg        <= 1'b1;
                end
            end
            if (emit)
            begin
                out_valid_reg    <= 1'b1;
                found_reg        <= any_reg;
                chosen_index_reg <= any_reg ? best_index_reg : '0;
                best_score_reg   <= '0;
                best_index_reg   <= '0;
                any_reg          <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign clearing     = state_reg == mbvs_pkg::ST_CLEAR;
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign chosen_index = chosen_index_reg;

`ifndef SYNTHESIS
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbvs_pkg::ST_CLEAR |-> !pop)
        else $error("queue popped during table clearing");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> chosen_index_reg == '0)
        else $error("none result carries a nonzero index");

    a_select_sets: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbvs_pkg::ST_SELECT |=> any_reg)
        else $error("selection did not register a candidate");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mbvs_pkg::ST_RATIO_W || state_reg == mbvs_pkg::ST_OLD_W
                      || state_reg == mbvs_pkg::ST_NEW_W || state_reg == mbvs_pkg::ST_DCOST_W
                      || state_reg == mbvs_pkg::ST_UCOST_W))
        else $error("divider finished outside a wait state");
`endif

endmodule

>>> design/milp_branch_variable_selector_unit.sv
// top level of the pseudo-cost branching variable selector
//
// input channel: in_valid / in_stall carry record items (mode 0) that fold an
// observed objective change into the pseudo-cost table, and offer items
// (mode 1) that present one variable's relaxation value for selection.
// output channel: out_valid / out_stall carry one result per offer marked
// last_offer: found and chosen_index of the first best candidate.
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 branch strategy, 1 integrality tolerance); the user must write it only
// while the block is idle, as the block does not enforce it. after reset
// the table's 1024 rows are swept to zero with in_stall high. a two entry
// queue decouples acceptance from execution; execution uses one bit-serial
// divider and one bit-serial multiplier, which set the rate: a record takes
// two or three divisions, a pseudo-cost offer up to two divisions and three
// products, a most fractional or non-candidate last offer no arithmetic,
// dropped items none.
// a result is registered and held while out_stall is high; the block keeps
// accepting items into the queue meanwhile and waits only to emit the next.
module milp_branch_variable_selector_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [mbvs_pkg::VAR_W-1:0]      var_index,
    input  logic                            direction,
    input  logic signed [31:0]              obj_change,
    input  logic [mbvs_pkg::FRAC_BITS-1:0]  branch_fraction,
    input  logic signed [31:0]              primal_value,
    input  logic                            is_integer,
    input  logic                            last_offer,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [mbvs_pkg::VAR_W-1:0]      chosen_index,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [15:0]                     cfg_data
);

    mbvs_pkg::entry_t head;
    logic             head_valid;
    logic             pop;
    logic             clearing;

    // accept and classify
    mbvs_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .var_index       (var_index),
        .direction       (direction),
        .obj_change      (obj_change),
        .branch_fraction (branch_fraction),
        .primal_value    (primal_value),
        .is_integer      (is_integer),
        .last_offer      (last_offer),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .clearing        (clearing),
        .pop             (pop),
        .head            (head),
        .head_valid      (head_valid)
    );

    // execute and select
    mbvs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .chosen_index (chosen_index)
    );

endmodule
